// ===== hdl/ptp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ptp_pkg - shared types and constants of the priority tune player
// request and result layouts, command and register codes, pulse helper
// ---------------------------------------------------------------------------
package ptp_pkg;

    // field widths
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 6;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 16;
    localparam int TONE_W   = 16;
    localparam int KIND_W   = 2;
    localparam int PRIO_W   = 8;
    localparam int LVL_W    = 3;
    localparam int PERIOD_W = 30;
    localparam int PULSE_W  = 29;
    localparam int POSO_W   = 6;
    localparam int ELAP_W   = 17;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_PAD_W  = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // command codes carried in tuser
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PLAY  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NOTE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UI_VOLUME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_VOLUME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOUR_VOLUME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_CODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_CODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_CODE  = 3'd5;

    // volume kinds
    localparam logic [KIND_W-1:0] KIND_UI    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALARM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HOUR  = 2'd2;
    localparam logic [LVL_W-1:0]  LVL_FIXED  = 3'd3;

    localparam logic [PRIO_W-1:0]   LOWEST_PRIORITY = 8'd0;
    localparam logic [PERIOD_W-1:0] DIVIDEND        = 30'd1000000000;
    localparam int                  DIV_STEPS       = 30;

    // request payload, last field in the lowest bits
    typedef struct packed {
        logic [PRIO_W-1:0] priority_req;
        logic [KIND_W-1:0] volume_kind;
        logic [TONE_W-1:0] note_tone;
        logic [LEN_W-1:0]  note_length;
        logic [WORD_W-1:0] tune_word;
        logic [IDX_W-1:0]  store_index;
    } in_data_t;

    // result payload, last field in the lowest bits
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [PRIO_W-1:0]    active_priority;
        logic [POSO_W-1:0]    tune_position;
        logic                 note_active;
        logic [PULSE_W-1:0]   pwm_pulse;
        logic [PERIOD_W-1:0]  pwm_period;
        logic                 pwm_on;
    } out_data_t;

    // pulse width from period and volume level
    function automatic logic [PULSE_W-1:0] pulse_of(input logic [PERIOD_W-1:0] per,
                                                    input logic [LVL_W-1:0] lvl);
        logic [PULSE_W-1:0] res;
        case (lvl)
            3'd0:    res = PULSE_W'(per >> 6);
            3'd1:    res = PULSE_W'(per >> 5);
            3'd2:    res = PULSE_W'(per >> 4);
            default: res = PULSE_W'(per >> 1);
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ptp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ptp_ram - generic single-write, single-read ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module ptp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/priority_tune_player.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// priority_tune_player - priority-arbitrated tone sequencer for a pwm buzzer
// tune store, note sequencer and a shared radix-2 divider for the period
// ---------------------------------------------------------------------------
// usage
//   s_* carries one request: s_tuser holds the command (tick, write word,
//   play tune, single note, stop), s_tdata the other request fields.
//   m_* returns one result per request: pwm state, period, pulse, note
//   activity, next tune position and held priority.
//   wr_en / wr_index / wr_data write the volume levels and the special
//   tone codes; they are to be written only while the player is idle;
//   the block itself does not enforce this.
// sequencing
//   ticks, word writes, stops and ignored codes are executed and reported;
//   a tick that ends a chained tune note fetches the next word. a note that
//   sounds runs the divider, 30 steps of one bit each; a fetched note first
//   reads the store, and a repeat word rewinds to the start and reads again.
//   s_tready is high only while the sequencer is idle: one request at a time.
// reset and stalls
//   reset clears the player state and restores the register defaults;
//   the tune store is not cleared and holds nothing valid until written.
//   a result waits in the output register while m_tready is low; the next
//   request is still taken and its result is held back until the slot frees.
// ---------------------------------------------------------------------------
module priority_tune_player #(
    parameter int TUNE_DEPTH = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // store_index, tune_word, note_length, note_tone, volume_kind, priority_req
    input  wire logic [ptp_pkg::IN_DATA_W-1:0]     s_tdata,
    // command
    input  wire logic [ptp_pkg::CMD_W-1:0]         s_tuser,
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // pwm_on, pwm_period, pwm_pulse, note_active, tune_position,
    // active_priority, zero fill
    output logic      [ptp_pkg::OUT_DATA_W-1:0]    m_tdata,
    // register write port
    input  wire logic                              wr_en,
    input  wire logic [ptp_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire logic [ptp_pkg::CFG_DATA_W-1:0]    wr_data
);

    import ptp_pkg::*;

    localparam int POS_W = $clog2(TUNE_DEPTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TUNE_DEPTH - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_EXEC       = 3'd1;
    localparam logic [2:0] S_FETCH      = 3'd2;
    localparam logic [2:0] S_FETCH_DATA = 3'd3;
    localparam logic [2:0] S_NOTE       = 3'd4;
    localparam logic [2:0] S_DIV        = 3'd5;
    localparam logic [2:0] S_REPORT     = 3'd6;

    // configuration registers
    logic [LVL_W-1:0]  ui_volume_reg;
    logic [LVL_W-1:0]  alarm_volume_reg;
    logic [LVL_W-1:0]  hour_volume_reg;
    logic [TONE_W-1:0] stop_code_reg;
    logic [TONE_W-1:0] pause_code_reg;
    logic [TONE_W-1:0] repeat_code_reg;

    // sequencer and request latch
    logic [2:0]        state_reg,     state_next;
    logic [CMD_W-1:0]  cmd_reg,       cmd_next;
    in_data_t          req_reg,       req_next;

    // note operands, shared by single notes and fetched words
    logic [LEN_W-1:0]  op_len_reg,    op_len_next;
    logic [TONE_W-1:0] op_tone_reg,   op_tone_next;
    logic [KIND_W-1:0] op_kind_reg,   op_kind_next;
    logic              op_follow_reg, op_follow_next;

    // divider
    logic [TONE_W-1:0]   rem_reg,     rem_next;
    logic [PERIOD_W-1:0] quo_reg,     quo_next;
    logic [4:0]          cnt_reg,     cnt_next;

    // player state
    logic [POS_W-1:0]    pos_reg,     pos_next;
    logic [PRIO_W-1:0]   held_reg,    held_next;
    logic [LEN_W-1:0]    dur_reg,     dur_next;
    logic [ELAP_W-1:0]   elapsed_reg, elapsed_next;
    logic                chain_reg,   chain_next;
    logic [KIND_W-1:0]   tkind_reg,   tkind_next;
    logic                running_reg, running_next;
    logic [PERIOD_W-1:0] period_reg,  period_next;
    logic [PULSE_W-1:0]  pulse_reg,   pulse_next;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    out_data_t           out_reg,      out_next;

    // helpers
    logic                halt;
    logic [ELAP_W-1:0]   elapsed_inc;
    logic [POS_W-1:0]    pos_inc;
    logic [TONE_W:0]     rem_sh;
    logic                div_ge;
    logic [TONE_W-1:0]   rem_step;
    logic [PERIOD_W-1:0] quo_step;
    logic [LVL_W-1:0]    note_level;

    // tune store
    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [WORD_W-1:0]   rd_word;

    assign ram_wr_en = (state_reg == S_EXEC) && (cmd_reg == CMD_WRITE)
                     && (32'(req_reg.store_index) < TUNE_DEPTH);

    ptp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TUNE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (POS_W'(req_reg.store_index)),
        .wr_data (req_reg.tune_word),
        .rd_en   (ram_rd_en),
        .rd_addr (pos_reg),
        .rd_data (rd_word)
    );

    // saturating millisecond count, wrapping tune position
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + ELAP_W'(1);
    assign pos_inc     = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_W'(1);

    // one restoring divide step: remainder stays below the tone
    assign rem_sh   = {rem_reg, quo_reg[PERIOD_W-1]};
    assign div_ge   = rem_sh >= {1'b0, op_tone_reg};
    assign rem_step = div_ge ? TONE_W'(rem_sh - {1'b0, op_tone_reg}) : rem_sh[TONE_W-1:0];
    assign quo_step = {quo_reg[PERIOD_W-2:0], div_ge};

    // volume level picked by the note's kind
    always_comb
    begin
        case (op_kind_reg)
            KIND_UI:    note_level = ui_volume_reg;
            KIND_ALARM: note_level = alarm_volume_reg;
            KIND_HOUR:  note_level = hour_volume_reg;
            default:    note_level = LVL_FIXED;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        req_next       = req_reg;
        op_len_next    = op_len_reg;
        op_tone_next   = op_tone_reg;
        op_kind_next   = op_kind_reg;
        op_follow_next = op_follow_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        held_next      = held_reg;
        dur_next       = dur_reg;
        elapsed_next   = elapsed_reg;
        chain_next     = chain_reg;
        tkind_next     = tkind_reg;
        running_next   = running_reg;
        period_next    = period_reg;
        pulse_next     = pulse_reg;
        out_next       = out_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        ram_rd_en      = 1'b0;
        halt           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    req_next   = in_data_t'(s_tdata);
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_REPORT;
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (dur_reg != '0)
                        begin
                            elapsed_next = elapsed_inc;
                            if (elapsed_inc > {1'b0, dur_reg})
                            begin
                                halt = 1'b1;
                                if (chain_reg)
                                begin
                                    state_next = S_FETCH;
                                end
                            end
                        end
                    end
                    CMD_WRITE:
                    begin
                        // store write is driven straight from the latch
                    end
                    CMD_PLAY:
                    begin
                        if (req_reg.priority_req >= held_reg)
                        begin
                            tkind_next = req_reg.volume_kind;
                            held_next  = req_reg.priority_req;
                            pos_next   = '0;
                            state_next = S_FETCH;
                        end
                    end
                    CMD_NOTE:
                    begin
                        if (req_reg.priority_req >= held_reg)
                        begin
                            op_len_next    = req_reg.note_length;
                            op_tone_next   = req_reg.note_tone;
                            op_kind_next   = req_reg.volume_kind;
                            op_follow_next = 1'b0;
                            state_next     = S_NOTE;
                        end
                    end
                    CMD_STOP:
                    begin
                        halt = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_FETCH:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_FETCH_DATA;
            end

            S_FETCH_DATA:
            begin
                if (rd_word[WORD_W-1:LEN_W] != repeat_code_reg)
                begin
                    pos_next       = pos_inc;
                    op_len_next    = rd_word[LEN_W-1:0];
                    op_tone_next   = rd_word[WORD_W-1:LEN_W];
                    op_kind_next   = tkind_reg;
                    op_follow_next = 1'b1;
                    state_next     = S_NOTE;
                end
                else if (pos_reg == '0)
                begin
                    // repeat at the start of the tune
                    pos_next   = pos_inc;
                    halt       = 1'b1;
                    state_next = S_REPORT;
                end
                else
                begin
                    // rewind and read the first word
                    pos_next   = '0;
                    state_next = S_FETCH;
                end
            end

            S_NOTE:
            begin
                state_next = S_REPORT;
                if (op_tone_reg == stop_code_reg)
                begin
                    halt = 1'b1;
                end
                else if (op_tone_reg == pause_code_reg)
                begin
                    dur_next     = op_len_reg;
                    elapsed_next = '0;
                    chain_next   = op_follow_reg;
                end
                else if (op_tone_reg == '0)
                begin
                    halt = 1'b1;
                end
                else
                begin
                    dur_next     = op_len_reg;
                    elapsed_next = '0;
                    chain_next   = op_follow_reg;
                    rem_next     = '0;
                    quo_next     = DIVIDEND;
                    cnt_next     = 5'(DIV_STEPS - 1);
                    state_next   = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    period_next  = quo_step;
                    pulse_next   = pulse_of(quo_step, note_level);
                    running_next = 1'b1;
                    state_next   = S_REPORT;
                end
            end

            S_REPORT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next.pad             = '0;
                    out_next.active_priority = held_reg;
                    out_next.tune_position   = POSO_W'(pos_reg);
                    out_next.note_active     = (dur_reg != '0);
                    out_next.pwm_pulse       = pulse_reg;
                    out_next.pwm_period      = period_reg;
                    out_next.pwm_on          = running_reg;
                    m_tvalid_next            = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // player stop, period and pulse keep their values
        if (halt)
        begin
            held_next    = LOWEST_PRIORITY;
            dur_next     = '0;
            elapsed_next = '0;
            chain_next   = 1'b0;
            running_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            held_reg     <= LOWEST_PRIORITY;
            dur_reg      <= '0;
            elapsed_reg  <= '0;
            chain_reg    <= 1'b0;
            tkind_reg    <= '0;
            running_reg  <= 1'b0;
            period_reg   <= '0;
            pulse_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            held_reg     <= held_next;
            dur_reg      <= dur_next;
            elapsed_reg  <= elapsed_next;
            chain_reg    <= chain_next;
            tkind_reg    <= tkind_next;
            running_reg  <= running_next;
            period_reg   <= period_next;
            pulse_reg    <= pulse_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        req_reg       <= req_next;
        op_len_reg    <= op_len_next;
        op_tone_reg   <= op_tone_next;
        op_kind_reg   <= op_kind_next;
        op_follow_reg <= op_follow_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        out_reg       <= out_next;
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ui_volume_reg    <= 3'd3;
            alarm_volume_reg <= 3'd3;
            hour_volume_reg  <= 3'd3;
            stop_code_reg    <= 16'd0;
            pause_code_reg   <= 16'd1;
            repeat_code_reg  <= 16'hFFFF;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_UI_VOLUME:    ui_volume_reg    <= wr_data[LVL_W-1:0];
                REG_ALARM_VOLUME: alarm_volume_reg <= wr_data[LVL_W-1:0];
                REG_HOUR_VOLUME:  hour_volume_reg  <= wr_data[LVL_W-1:0];
                REG_STOP_CODE:    stop_code_reg    <= wr_data;
                REG_PAUSE_CODE:   pause_code_reg   <= wr_data;
                REG_REPEAT_CODE:  repeat_code_reg  <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule
`default_nettype wire

// ===== hdl/ptp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ptp_checker - port-level checks for the priority tune player
// result channel behaviour and consistency of the reported pwm values
// ---------------------------------------------------------------------------
module ptp_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [ptp_pkg::OUT_DATA_W-1:0] m_tdata
);

    import ptp_pkg::*;

    out_data_t res;

    assign res = out_data_t'(m_tdata);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // pulse never exceeds half the period
    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({res.pwm_pulse, 1'b0} <= res.pwm_period))
        else $error("pulse wider than half the period");

    // a running buzzer has a real period
    a_period_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.pwm_on |-> res.pwm_period != '0)
        else $error("pwm running with zero period");

endmodule

bind priority_tune_player ptp_checker u_ptp_checker (.*);
`default_nettype wire

// ===== tb/priority_tune_player_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// priority_tune_player_checker - result checker for the tune player
// follows register writes and accepted requests, predicts the pwm and
// sequencer state after each request and compares it with every result
// ---------------------------------------------------------------------------
module priority_tune_player_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [ptp_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic [ptp_pkg::CMD_W-1:0]      s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [ptp_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                           wr_en,
    input  wire logic [ptp_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [ptp_pkg::CFG_DATA_W-1:0] wr_data,
    output int                                  mismatch_count,
    output int                                  awaited_count,
    output int                                  compared_count
);

    import ptp_pkg::*;

    // register copies
    logic [LVL_W-1:0]    lvl_ui, lvl_alarm, lvl_chime;
    logic [TONE_W-1:0]   code_stop, code_pause, code_repeat;

    // player state
    logic [WORD_W-1:0]   tune_words [64];
    logic [IDX_W-1:0]    next_pos;
    logic [PRIO_W-1:0]   held_prio;
    logic [LEN_W-1:0]    note_len;
    logic [ELAP_W-1:0]   elapsed;
    logic                chain;
    logic [KIND_W-1:0]   tune_kind;
    logic                sounding;
    logic [PERIOD_W-1:0] period_val;
    logic [PULSE_W-1:0]  pulse_val;

    out_data_t awaited_status [$];

    task automatic silence_player();
        held_prio = LOWEST_PRIORITY;
        note_len  = '0;
        elapsed   = '0;
        chain     = 1'b0;
        sounding  = 1'b0;
    endtask

    function automatic logic [LVL_W-1:0] level_for(input logic [KIND_W-1:0] kind);
        case (kind)
            KIND_UI:    return lvl_ui;
            KIND_ALARM: return lvl_alarm;
            KIND_HOUR:  return lvl_chime;
            default:    return LVL_FIXED;
        endcase
    endfunction

    task automatic start_tone(input logic [LEN_W-1:0] len, input logic [TONE_W-1:0] tone,
                              input logic [KIND_W-1:0] kind, input logic [PRIO_W-1:0] prio,
                              input logic follow);
        int unsigned      per;
        logic [LVL_W-1:0] lvl;
        if (prio >= held_prio)
        begin
            if (tone == code_stop)
            begin
                silence_player();
            end
            else if (tone == code_pause)
            begin
                note_len = len;
                elapsed  = '0;
                chain    = follow;
            end
            else if (tone == '0)
            begin
                silence_player();
            end
            else
            begin
                note_len   = len;
                elapsed    = '0;
                chain      = follow;
                per        = 32'd1000000000 / 32'(tone);
                lvl        = level_for(kind);
                period_val = PERIOD_W'(per);
                case (lvl)
                    3'd0:    pulse_val = PULSE_W'(per / 64);
                    3'd1:    pulse_val = PULSE_W'(per / 32);
                    3'd2:    pulse_val = PULSE_W'(per / 16);
                    default: pulse_val = PULSE_W'(per / 2);
                endcase
                sounding = 1'b1;
            end
        end
    endtask

    // a repeat word rewinds once; a repeat at the start halts
    task automatic fetch_next();
        logic [IDX_W-1:0]  at;
        logic [WORD_W-1:0] w;
        logic              done;
        logic              give_up;
        at      = next_pos;
        done    = 1'b0;
        give_up = 1'b0;
        for (int tries = 0; tries < 2; tries++)
        begin
            if (!done && !give_up)
            begin
                w        = tune_words[at];
                next_pos = at + 1'b1;
                if (w[31:16] != code_repeat)
                begin
                    start_tone(w[15:0], w[31:16], tune_kind, held_prio, 1'b1);
                    done = 1'b1;
                end
                else if (at == '0)
                    give_up = 1'b1;
                else
                    at = '0;
            end
        end
        if (!done)
            silence_player();
    endtask

    task automatic apply_request(input logic [CMD_W-1:0] cmd, input in_data_t req);
        logic follow;
        case (cmd)
            CMD_TICK:
                if (note_len != '0)
                begin
                    if (elapsed < {ELAP_W{1'b1}})
                        elapsed = elapsed + 1'b1;
                    if (elapsed > {1'b0, note_len})
                    begin
                        follow = chain;
                        silence_player();
                        if (follow)
                            fetch_next();
                    end
                end
            CMD_WRITE:
                tune_words[req.store_index] = req.tune_word;
            CMD_PLAY:
                if (req.priority_req >= held_prio)
                begin
                    tune_kind = req.volume_kind;
                    held_prio = req.priority_req;
                    next_pos  = '0;
                    fetch_next();
                end
            CMD_NOTE:
                start_tone(req.note_length, req.note_tone, req.volume_kind,
                           req.priority_req, 1'b0);
            CMD_STOP:
                silence_player();
            default:
                ;
        endcase
    endtask

    function automatic out_data_t status_now();
        out_data_t s;
        s                 = '0;
        s.pwm_on          = sounding;
        s.pwm_period      = period_val;
        s.pwm_pulse       = pulse_val;
        s.note_active     = (note_len != '0);
        s.tune_position   = next_pos;
        s.active_priority = held_prio;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_data_t want;
        out_data_t got;
        if (!rst_n)
        begin
            lvl_ui         = 3'd3;
            lvl_alarm      = 3'd3;
            lvl_chime      = 3'd3;
            code_stop      = 16'd0;
            code_pause     = 16'd1;
            code_repeat    = 16'hFFFF;
            next_pos       = '0;
            held_prio      = LOWEST_PRIORITY;
            note_len       = '0;
            elapsed        = '0;
            chain          = 1'b0;
            tune_kind      = KIND_UI;
            sounding       = 1'b0;
            period_val     = '0;
            pulse_val      = '0;
            awaited_status.delete();
            mismatch_count = 0;
            compared_count = 0;
            awaited_count  = 0;
        end
        else
        begin
            if (wr_en)
                case (wr_index)
                    REG_UI_VOLUME:    lvl_ui      = wr_data[LVL_W-1:0];
                    REG_ALARM_VOLUME: lvl_alarm   = wr_data[LVL_W-1:0];
                    REG_HOUR_VOLUME:  lvl_chime   = wr_data[LVL_W-1:0];
                    REG_STOP_CODE:    code_stop   = wr_data;
                    REG_PAUSE_CODE:   code_pause  = wr_data;
                    REG_REPEAT_CODE:  code_repeat = wr_data;
                    default:          ;
                endcase
            if (s_tvalid && s_tready)
            begin
                apply_request(s_tuser, s_tdata);
                awaited_status.push_back(status_now());
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (awaited_status.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no request outstanding", $realtime);
                end
                else
                begin
                    want = awaited_status.pop_front();
                    compared_count++;
                    check_field("pwm_on", want.pwm_on, got.pwm_on);
                    check_field("pwm_period", want.pwm_period, got.pwm_period);
                    check_field("pwm_pulse", want.pwm_pulse, got.pwm_pulse);
                    check_field("note_active", want.note_active, got.note_active);
                    check_field("tune_position", want.tune_position, got.tune_position);
                    check_field("active_priority", want.active_priority,
                                got.active_priority);
                end
            end
            awaited_count = awaited_status.size();
        end
    end

endmodule

// ===== tb/priority_tune_player_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// priority_tune_player_tb - top level testbench of the tune player
// drives requests and register writes, varies idling on both channels and
// leaves prediction and comparison to the checker beside the block
// ---------------------------------------------------------------------------
module priority_tune_player_tb;
    import ptp_pkg::*;

    // unused command codes, the block must report state and change nothing
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

    localparam int PHASE_ITEMS   = 510;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [CMD_W-1:0]      s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data  = '0;

    int mismatch_count;
    int awaited_count;
    int compared_count;

    // idling odds in percent, changed per phase
    int   tx_gap_pct   = 10;
    int   rx_stall_pct = 53;
    logic rx_hold      = 1'b0;

    // special codes as currently programmed, steer the tone picker
    logic [TONE_W-1:0] stop_val   = 16'd0;
    logic [TONE_W-1:0] pause_val  = 16'd1;
    logic [TONE_W-1:0] repeat_val = 16'hFFFF;

    int requests_sent = 0;
    int plays_sent    = 0;
    int notes_sent    = 0;
    int ticks_sent    = 0;

    priority_tune_player #(
        .TUNE_DEPTH (64)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    priority_tune_player_checker tone_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count),
        .compared_count (compared_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // result side: random stalls, forced low while a hold-off runs
    initial
    begin
        forever
        begin
            @(posedge clk);
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // hard limit on the whole run
    initial
    begin
        #5000000;
        $display("priority_tune_player verification failed");
        $finish;
    end

    // random filler for the fields a command does not look at
    function automatic in_data_t noise_fields();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[IN_DATA_W-1:0];
    endfunction

    // one request; valid stays high on acceptance so back-to-back
    // requests leave no gap in valid, callers always start at a rising edge
    task automatic send_req(input logic [CMD_W-1:0] cmd, input in_data_t req);
        int gap;
        if ($urandom_range(99) < tx_gap_pct)
        begin
            gap = $urandom_range(4, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic tick();
        send_req(CMD_TICK, noise_fields());
        ticks_sent++;
    endtask

    task automatic put_word(input logic [IDX_W-1:0] idx, input logic [TONE_W-1:0] tone,
                            input logic [LEN_W-1:0] len);
        in_data_t req;
        req             = noise_fields();
        req.store_index = idx;
        req.tune_word   = {tone, len};
        send_req(CMD_WRITE, req);
    endtask

    task automatic play(input logic [KIND_W-1:0] kind, input logic [PRIO_W-1:0] prio);
        in_data_t req;
        req              = noise_fields();
        req.volume_kind  = kind;
        req.priority_req = prio;
        send_req(CMD_PLAY, req);
        plays_sent++;
    endtask

    task automatic note(input logic [LEN_W-1:0] len, input logic [TONE_W-1:0] tone,
                        input logic [KIND_W-1:0] kind, input logic [PRIO_W-1:0] prio);
        in_data_t req;
        req              = noise_fields();
        req.note_length  = len;
        req.note_tone    = tone;
        req.volume_kind  = kind;
        req.priority_req = prio;
        send_req(CMD_NOTE, req);
        notes_sent++;
    endtask

    task automatic halt();
        send_req(CMD_STOP, noise_fields());
    endtask

    // mostly ordinary tones, with the special codes and zero mixed in
    function automatic logic [TONE_W-1:0] pick_tone();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return stop_val;
        else if (r < 16)
            return pause_val;
        else if (r < 22)
            return repeat_val;
        else if (r < 27)
            return 16'd0;
        else if (r < 32)
            return ($urandom_range(1) != 0) ? 16'hFFFF : 16'd1;
        else
            return TONE_W'($urandom_range(65535, 1));
    endfunction

    function automatic logic [TONE_W-1:0] plain_tone();
        logic [TONE_W-1:0] t;
        t = TONE_W'($urandom_range(65535, 1));
        while (t == stop_val || t == pause_val || t == repeat_val)
            t = TONE_W'($urandom_range(65535, 1));
        return t;
    endfunction

    // short notes keep tunes moving; now and then an endless one
    function automatic logic [LEN_W-1:0] short_len();
        if ($urandom_range(99) < 5)
            return '0;
        return LEN_W'($urandom_range(3, 1));
    endfunction

    // write a short tune from position 0, play it and feed ticks,
    // with the odd interruption thrown in
    task automatic tune_scenario();
        int n;
        int steps;
        if ($urandom_range(99) < 30)
            halt();
        n = $urandom_range(6, 1);
        for (int k = 0; k < n; k++)
            put_word(IDX_W'(k), pick_tone(), short_len());
        case ($urandom_range(2))
            0:       put_word(IDX_W'(n), stop_val, LEN_W'($urandom));
            1:       put_word(IDX_W'(n), repeat_val, LEN_W'($urandom));
            default: ;
        endcase
        play(KIND_W'($urandom),
             PRIO_W'(($urandom_range(1) != 0) ? $urandom_range(255) : $urandom_range(40)));
        steps = $urandom_range(4 * n + 4, n);
        for (int k = 0; k < steps; k++)
        begin
            case ($urandom_range(19))
                0:       note(short_len(), pick_tone(), KIND_W'($urandom), PRIO_W'($urandom));
                1:       play(KIND_W'($urandom), PRIO_W'($urandom));
                2:       put_word(IDX_W'($urandom), pick_tone(), short_len());
                3:       halt();
                default: tick();
            endcase
        end
    endtask

    task automatic note_scenario();
        logic [LEN_W-1:0] len;
        int               ticks;
        len = ($urandom_range(99) < 80) ? short_len() : LEN_W'($urandom);
        note(len, pick_tone(), KIND_W'($urandom), PRIO_W'($urandom));
        ticks = $urandom_range(5);
        repeat (ticks) tick();
    endtask

    // stop offering, then wait until every result is back and the block
    // has had time to go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (awaited_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all six registers in consecutive cycles, only while idle
    task automatic set_config(input logic [LVL_W-1:0] ui, input logic [LVL_W-1:0] alarm,
                              input logic [LVL_W-1:0] hour, input logic [TONE_W-1:0] stp,
                              input logic [TONE_W-1:0] pse, input logic [TONE_W-1:0] rpt);
        wr_en    <= 1'b1;
        wr_index <= REG_UI_VOLUME;
        wr_data  <= CFG_DATA_W'(ui);
        @(posedge clk);
        wr_index <= REG_ALARM_VOLUME;
        wr_data  <= CFG_DATA_W'(alarm);
        @(posedge clk);
        wr_index <= REG_HOUR_VOLUME;
        wr_data  <= CFG_DATA_W'(hour);
        @(posedge clk);
        wr_index <= REG_STOP_CODE;
        wr_data  <= stp;
        @(posedge clk);
        wr_index <= REG_PAUSE_CODE;
        wr_data  <= pse;
        @(posedge clk);
        wr_index <= REG_REPEAT_CODE;
        wr_data  <= rpt;
        @(posedge clk);
        wr_en    <= 1'b0;
        @(posedge clk);
        stop_val   = stp;
        pause_val  = pse;
        repeat_val = rpt;
    endtask

    // one phase of random traffic; optionally the receiver holds off
    // for a long stretch while requests keep coming
    task automatic run_phase(input int gap_pct, input int stall_pct, input int items,
                             input bit with_hold);
        int target;
        int first;
        int r;
        bit held;
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        first  = requests_sent;
        target = requests_sent + items;
        held   = 1'b0;
        while (requests_sent < target)
        begin
            if (with_hold && !held && requests_sent > first + 100)
            begin
                held = 1'b1;
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            r = $urandom_range(99);
            if (r < 50)
                tune_scenario();
            else if (r < 80)
                note_scenario();
            else
                send_req(CMD_W'($urandom_range(7)), noise_fields());
        end
        settle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole store first so no fetch can hit an unwritten word;
        // the first four words form a small tune with a pause and a rewind
        put_word(6'd0, 16'd440, 16'd1);
        put_word(6'd1, pause_val, 16'd1);
        put_word(6'd2, 16'd65534, 16'd1);
        put_word(6'd3, repeat_val, 16'd0);
        for (int k = 4; k < 64; k++)
            put_word(IDX_W'(k), plain_tone(), short_len());

        // directed part, register values as after reset
        note(16'd0, 16'd1, KIND_OTHER, 8'd0);         // pause code as a note, endless
        tick();                                       // endless note ignores ticks
        note(16'd2, 16'hFFFF, KIND_HOUR, 8'd255);     // repeat code as plain tone
        repeat (3) tick();                            // note runs out
        play(KIND_ALARM, 8'd200);
        note(16'd5, 16'd1000, KIND_UI, 8'd100);       // below held priority
        play(KIND_UI, 8'd100);                        // below held priority
        repeat (2) tick();                            // silent pause follows
        repeat (2) tick();                            // highest tone
        repeat (2) tick();                            // repeat word rewinds
        halt();
        note(16'd3, pause_val, KIND_UI, 8'd0);        // pause as a single note
        note(16'd4, stop_val, KIND_ALARM, 8'd0);      // stop code as a note
        send_req(CMD_SPARE_LO, noise_fields());
        send_req(CMD_SPARE_HI, noise_fields());
        put_word(6'd63, 16'hFFFF, 16'hFFFF);
        put_word(6'd0, repeat_val, 16'd7);            // repeat at the start halts
        play(KIND_HOUR, 8'd0);
        settle();

        // sender idles lightly, receiver heavily
        set_config(3'd0, 3'd1, 3'd2, 16'd7, 16'hFFFF, 16'd1);
        run_phase(10, 53, PHASE_ITEMS, 1'b0);

        // the other way round; stop and repeat share one code here
        set_config(3'd7, 3'd7, 3'd3, 16'hFFFF, 16'd0, 16'hFFFF);
        run_phase(53, 10, PHASE_ITEMS, 1'b0);

        // no idling; one tune through all 64 words so the position wraps,
        // then random traffic with a long receiver hold-off
        set_config(3'd5, 3'd0, 3'd7, 16'd0, 16'd301, 16'd0);
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        for (int k = 0; k < 64; k++)
            put_word(IDX_W'(k), plain_tone(), 16'd1);
        play(KIND_HOUR, 8'd10);
        repeat (140) tick();
        halt();
        run_phase(0, 0, PHASE_ITEMS, 1'b1);

        $display("covered %0d requests: %0d tune plays, %0d single notes, %0d ticks",
                 requests_sent, plays_sent, notes_sent, ticks_sent);
        $display("reset values plus three register settings, %0d results compared",
                 compared_count);
        if (mismatch_count == 0)
            $display("priority_tune_player verification clean");
        else
            $display("priority_tune_player verification failed");
        $finish;
    end

endmodule
